/* hw/rtl/gpr5_pkg.sv */
// ============================================================================
// gpr5_pkg: shared types and constants of the pyramid reduce block
// Sizes, coordinate widths, the job passed from front to back, the result
// item and the 1-4-6-4-1 kernel sum used by both filter directions.
// ============================================================================
package gpr5_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int STORED_ROWS = 4;
  localparam int HALF_COLS   = (MAX_WIDTH + 1) / 2;

  localparam int ADDR_W  = $clog2(HALF_COLS);
  localparam int SLOT_W  = $clog2(STORED_ROWS);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PIX_W   = 8;
  localparam int HSUM_W  = 12;
  localparam int VSUM_W  = 16;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

  // Source of one vertical tap: the row sum of the current row, or a line
  // store slot.
  typedef struct packed {
    logic              cur;
    logic [SLOT_W-1:0] slot;
  } tap_src_t;

  typedef struct packed {
    logic [STORED_ROWS-1:0][HSUM_W-1:0] row;
    logic [HSUM_W-1:0]                  cur;
  } col_data_t;

  // Index 0 is the lower output row or column, index 1 the upper one.
  typedef struct packed {
    logic [1:0]                yv;
    logic [1:0]                xv;
    logic [1:0][COORD_W-1:0]   oy;
    logic [1:0][COORD_W-1:0]   ox;
    tap_src_t [1:0][4:0]       src;
    col_data_t [1:0]           col;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               run_last;
    logic               frame_last;
  } result_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // a + 4b + 6c + 4d + e on 12-bit operands.
  function automatic logic [VSUM_W-1:0] kern5(
    input logic [HSUM_W-1:0] a,
    input logic [HSUM_W-1:0] b,
    input logic [HSUM_W-1:0] c,
    input logic [HSUM_W-1:0] d,
    input logic [HSUM_W-1:0] e
  );
    logic [VSUM_W-1:0] xa, xb, xc, xd, xe;
    xa = VSUM_W'(a);
    xb = VSUM_W'(b);
    xc = VSUM_W'(c);
    xd = VSUM_W'(d);
    xe = VSUM_W'(e);
    return xa + (xb << 2) + (xc << 2) + (xc << 1) + (xd << 2) + xe;
  endfunction

endpackage

/* hw/rtl/gpr5_front.sv */
// ============================================================================
// gpr5_front: pixel intake, horizontal filter and line store
// Tracks the raster position, forms the horizontal sums, writes the even
// column sums into the four-row line store and builds one job for every
// pixel that completes outputs, with the stored sums it needs.
// ============================================================================
module gpr5_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [gpr5_pkg::PIX_W-1:0]    in_pixel,
  input  logic                          cfg_we,
  input  logic [gpr5_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpr5_pkg::CFG_W-1:0]    cfg_wdata,
  input  gpr5_pkg::q_stat_t             q_stat,
  output logic                          job_push,
  output gpr5_pkg::job_t                job
);
  import gpr5_pkg::*;

  logic [COL_W-1:0]  wm1_r, wm1_nxt;
  logic [ROW_W-1:0]  hm1_r, hm1_nxt;
  logic [COL_W-1:0]  c_r, c_nxt;
  logic [ROW_W-1:0]  r_r, r_nxt;
  logic [PIX_W-1:0]  win_r [4];
  logic [PIX_W-1:0]  sw [4];

  logic              pend_v_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [HSUM_W-1:0] pend_data_r;

  logic              f1_v_r;
  job_t              f1_r, f1_nxt;

  logic [HSUM_W-1:0] mem [STORED_ROWS][HALF_COLS];
  logic [STORED_ROWS-1:0][HSUM_W-1:0] rd0_r, rd1_r;

  logic              accept, lastcol, first;
  logic              x_a, x_b, y_a, y_b, has_out;
  logic [HSUM_W-1:0] hsv0, hsv1, hsv2;
  logic [COL_W-2:0]  c_half;
  logic [ROW_W-2:0]  r_half;
  logic [ROW_W-1:0]  r_even;
  logic [ADDR_W-1:0] ra0, ra1;

  logic              pw_en;
  logic [ADDR_W-1:0] pw_addr;
  logic [HSUM_W-1:0] pw_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [ADDR_W-1:0] wr_addr;
  logic [HSUM_W-1:0] wr_data;

  // Job queue entries plus the job still in the read stage.
  assign full = ((QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(f1_v_r))
                >= (QCNT_W+1)'(QDEPTH);
  assign accept = push && !full;

  assign lastcol = (c_r == wm1_r);
  assign first   = (c_r == '0);
  assign c_half  = c_r[COL_W-1:1];
  assign r_half  = r_r[ROW_W-1:1];
  assign r_even  = {r_half, 1'b0};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sw[k] = first ? in_pixel : win_r[k];
    end
  end

  assign hsv0 = HSUM_W'(kern5(HSUM_W'(sw[3]), HSUM_W'(sw[2]), HSUM_W'(sw[1]),
                              HSUM_W'(sw[0]), HSUM_W'(in_pixel)));
  assign hsv1 = HSUM_W'(kern5(HSUM_W'(sw[2]), HSUM_W'(sw[1]), HSUM_W'(sw[0]),
                              HSUM_W'(in_pixel), HSUM_W'(in_pixel)));
  assign hsv2 = HSUM_W'(kern5(HSUM_W'(sw[1]), HSUM_W'(sw[0]), HSUM_W'(in_pixel),
                              HSUM_W'(in_pixel), HSUM_W'(in_pixel)));

  // Lower output column ends at an even column two past its center; the
  // upper one is the last output column, finished at the end of the row.
  assign x_a = !c_r[0] && (c_half != '0);
  assign x_b = lastcol;
  assign y_a = !r_r[0] && (r_half != '0);
  assign y_b = (r_r == hm1_r);
  assign has_out = (x_a || x_b) && (y_a || y_b);

  assign ra0 = ADDR_W'(c_half - 1'b1);
  assign ra1 = ADDR_W'(c_half);

  // Horizontal sums of even columns. At the end of a row with an even last
  // column two sums complete; the last one is written in the cycle after.
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = ra1;
    pw_data = hsv2;
    if (x_a) begin
      pw_en   = 1'b1;
      pw_addr = ra0;
      pw_data = hsv0;
    end else if (lastcol && c_r[0]) begin
      pw_en   = 1'b1;
      pw_data = hsv1;
    end else if (lastcol) begin
      pw_en   = 1'b1;
    end
    pw_en = pw_en && accept;
  end

  always_comb begin
    if (pend_v_r) begin
      wr_en   = 1'b1;
      wr_slot = pend_slot_r;
      wr_addr = pend_addr_r;
      wr_data = pend_data_r;
    end else begin
      wr_en   = pw_en;
      wr_slot = r_r[SLOT_W-1:0];
      wr_addr = pw_addr;
      wr_data = pw_data;
    end
  end

  // Job contents known at intake; the stored sums join from the read registers.
  always_comb begin
    logic [ROW_W:0] t, yy, off;
    f1_nxt = '0;
    f1_nxt.yv = {y_b, y_a};
    f1_nxt.xv = {x_b, x_a};
    f1_nxt.oy[0] = COORD_W'(r_half - 1'b1);
    f1_nxt.oy[1] = COORD_W'(r_half);
    f1_nxt.ox[0] = COORD_W'(c_half - 1'b1);
    f1_nxt.ox[1] = COORD_W'(c_half);
    f1_nxt.col[0].cur = hsv0;
    f1_nxt.col[1].cur = c_r[0] ? hsv1 : hsv2;
    for (int yi = 0; yi < 2; yi++) begin
      off = (yi == 0) ? (ROW_W+1)'(4) : (ROW_W+1)'(2);
      for (int k = 0; k < 5; k++) begin
        t = (ROW_W+1)'(r_even) + (ROW_W+1)'(k);
        if (t < off) begin
          yy = '0;
        end else begin
          yy = t - off;
        end
        if (yy > (ROW_W+1)'(hm1_r)) begin
          yy = (ROW_W+1)'(hm1_r);
        end
        f1_nxt.src[yi][k].cur  = (yy == (ROW_W+1)'(r_r));
        f1_nxt.src[yi][k].slot = yy[SLOT_W-1:0];
      end
    end
  end

  always_comb begin
    wm1_nxt = wm1_r;
    hm1_nxt = hm1_r;
    c_nxt   = c_r;
    r_nxt   = r_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH: begin
          if (cfg_wdata == '0) begin
            wm1_nxt = '0;
          end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            wm1_nxt = COL_W'(MAX_WIDTH - 1);
          end else begin
            wm1_nxt = COL_W'(cfg_wdata - 1'b1);
          end
        end
        CFG_HEIGHT: begin
          if (cfg_wdata == '0) begin
            hm1_nxt = '0;
          end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
            hm1_nxt = ROW_W'(MAX_HEIGHT - 1);
          end else begin
            hm1_nxt = ROW_W'(cfg_wdata - 1'b1);
          end
        end
        default: begin
        end
      endcase
      c_nxt = '0;
      r_nxt = '0;
    end else if (accept) begin
      if (lastcol) begin
        c_nxt = '0;
        r_nxt = (r_r == hm1_r) ? '0 : r_r + 1'b1;
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r    <= COL_W'(WIDTH_RST - 1'b1);
      hm1_r    <= ROW_W'(HEIGHT_RST - 1'b1);
      c_r      <= '0;
      r_r      <= '0;
      pend_v_r <= 1'b0;
      f1_v_r   <= 1'b0;
    end else begin
      wm1_r    <= wm1_nxt;
      hm1_r    <= hm1_nxt;
      c_r      <= c_nxt;
      r_r      <= r_nxt;
      pend_v_r <= accept && lastcol && x_a;
      f1_v_r   <= accept && has_out;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= in_pixel;
      for (int k = 1; k < 4; k++) begin
        win_r[k] <= sw[k-1];
      end
      pend_slot_r <= r_r[SLOT_W-1:0];
      pend_addr_r <= ra1;
      pend_data_r <= hsv2;
      f1_r        <= f1_nxt;
    end
  end

  // Line store: reads see the contents from before this cycle's write.
  always_ff @(posedge clk) begin
    if (accept && has_out) begin
      for (int b = 0; b < STORED_ROWS; b++) begin
        rd0_r[b] <= mem[b][ra0];
        rd1_r[b] <= mem[b][ra1];
      end
    end
    if (wr_en) begin
      mem[wr_slot][wr_addr] <= wr_data;
    end
  end

  always_comb begin
    job            = f1_r;
    job.col[0].row = rd0_r;
    job.col[1].row = rd1_r;
  end

  assign job_push = f1_v_r;

endmodule

/* hw/rtl/gpr5_job_q.sv */
// ============================================================================
// gpr5_job_q: job queue between intake and output stages
// A four-entry register queue of jobs with a count for the intake credit.
// ============================================================================
module gpr5_job_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gpr5_pkg::job_t     din,
  input  logic               pop,
  output gpr5_pkg::job_t     dout,
  output gpr5_pkg::q_stat_t  stat
);
  import gpr5_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign dout       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

/* hw/rtl/gpr5_back.sv */
// ============================================================================
// gpr5_back: vertical filter and result queue
// Walks the up to four outputs of a job in row, then column order, forms
// each vertical sum with rounding and queues the result items.
// ============================================================================
module gpr5_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gpr5_pkg::q_stat_t               q_stat,
  input  gpr5_pkg::job_t                  q_job,
  output logic                            q_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic [gpr5_pkg::PIX_W-1:0]      out_pixel,
  output logic [gpr5_pkg::COORD_W-1:0]    out_col,
  output logic [gpr5_pkg::COORD_W-1:0]    out_row,
  output logic                            out_run_last,
  output logic                            out_frame_last
);
  import gpr5_pkg::*;

  job_t              job_r;
  logic              busy_r;
  logic [3:0]        rem_r;
  logic [1:0]        sel;
  logic [3:0]        rem_after;
  logic              emit, fin, load;
  logic              yi, xi;
  logic [HSUM_W-1:0] tap [5];
  logic [VSUM_W-1:0] vsum;
  result_t           res;

  result_t           rq_r [QDEPTH];
  logic [QPTR_W-1:0] rq_wp_r, rq_rp_r;
  logic [QCNT_W-1:0] rq_cnt_r;
  logic              rq_pop;

  function automatic logic [3:0] combo_mask(input job_t j);
    return {j.yv[1] & j.xv[1], j.yv[1] & j.xv[0],
            j.yv[0] & j.xv[1], j.yv[0] & j.xv[0]};
  endfunction

  always_comb begin
    if (rem_r[0]) begin
      sel = 2'd0;
    end else if (rem_r[1]) begin
      sel = 2'd1;
    end else if (rem_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign rem_after = rem_r & ~(4'b0001 << sel);
  assign emit      = busy_r && (rq_cnt_r != QCNT_W'(QDEPTH));
  assign fin       = emit && (rem_after == '0);
  assign load      = !q_stat.empty && (!busy_r || fin);
  assign q_pop     = load;

  assign yi = sel[1];
  assign xi = sel[0];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      if (job_r.src[yi][k].cur) begin
        tap[k] = job_r.col[xi].cur;
      end else begin
        tap[k] = job_r.col[xi].row[job_r.src[yi][k].slot];
      end
    end
  end

  assign vsum = kern5(tap[0], tap[1], tap[2], tap[3], tap[4]) + VSUM_W'(128);

  always_comb begin
    res.pixel      = vsum[VSUM_W-1:VSUM_W-PIX_W];
    res.col        = job_r.ox[xi];
    res.row        = job_r.oy[yi];
    res.run_last   = (rem_after == '0);
    // Only the bottom-right output of the last row and column is final.
    res.frame_last = (sel == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      rem_r  <= combo_mask(q_job);
    end else if (fin) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else if (emit) begin
      rem_r  <= rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
  end

  assign rq_pop = pop && (rq_cnt_r != '0);
  assign empty  = (rq_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r  <= '0;
      rq_rp_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (emit) begin
        rq_wp_r <= rq_wp_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rp_r <= rq_rp_r + 1'b1;
      end
      rq_cnt_r <= rq_cnt_r + QCNT_W'(emit) - QCNT_W'(rq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rq_r[rq_wp_r] <= res;
    end
  end

  assign out_pixel      = rq_r[rq_rp_r].pixel;
  assign out_col        = rq_r[rq_rp_r].col;
  assign out_row        = rq_r[rq_rp_r].row;
  assign out_run_last   = rq_r[rq_rp_r].run_last;
  assign out_frame_last = rq_r[rq_rp_r].frame_last;

endmodule

/* hw/rtl/gaussian_pyramid_reduce_5tap.sv */
// ============================================================================
// gaussian_pyramid_reduce_5tap: one level of 5-tap binomial pyramid reduce
// Raster luma in, half-size blurred image out with coordinates.
//
//   Channel   Direction  Handshake          Payload
//   input     in         push / full        in_pixel
//   result    out        empty / pop        out_pixel, out_col, out_row,
//                                           out_run_last, out_frame_last
//   config    in         cfg_we             cfg_index, cfg_wdata
//
// One pixel is taken per clock while full is low. Results leave at one per
// clock while the result queue has room, so a pixel that completes four
// outputs holds the result side until all four are out. A result passes
// store read, job queue, vertical job register, then the vertical sum into
// the result queue. full rises once the queue and the store read stage hold
// four jobs in all. Reset is synchronous and restores a 640 x 480 frame;
// the line store needs no clearing: no entry is used before it is written.
// ============================================================================
module gaussian_pyramid_reduce_5tap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [gpr5_pkg::PIX_W-1:0]      in_pixel,
  output logic                            empty,
  input  logic                            pop,
  output logic [gpr5_pkg::PIX_W-1:0]      out_pixel,
  output logic [gpr5_pkg::COORD_W-1:0]    out_col,
  output logic [gpr5_pkg::COORD_W-1:0]    out_row,
  output logic                            out_run_last,
  output logic                            out_frame_last,
  input  logic                            cfg_we,
  input  logic [gpr5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpr5_pkg::CFG_W-1:0]      cfg_wdata
);
  import gpr5_pkg::*;

  job_t    fj, bj;
  logic    fj_push, bj_pop;
  q_stat_t qs;

  gpr5_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_pixel  (in_pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (qs),
    .job_push  (fj_push),
    .job       (fj)
  );

  gpr5_job_q u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fj_push),
    .din   (fj),
    .pop   (bj_pop),
    .dout  (bj),
    .stat  (qs)
  );

  gpr5_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (qs),
    .q_job          (bj),
    .q_pop          (bj_pop),
    .empty          (empty),
    .pop            (pop),
    .out_pixel      (out_pixel),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule

/* hw/rtl/gpr5_checker.sv */
// ============================================================================
// gpr5_checker: port-level checks of the pyramid reduce block
// Reset state of both queues, a held result head and result flag rules.
// ============================================================================
module gpr5_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input logic [gpr5_pkg::PIX_W-1:0]      out_pixel,
  input logic [gpr5_pkg::COORD_W-1:0]    out_col,
  input logic [gpr5_pkg::COORD_W-1:0]    out_row,
  input logic                            out_run_last,
  input logic                            out_frame_last
);

  // After reset no result is waiting.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  // After reset the input side takes pixels.
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  // A waiting result that is not taken stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel) && $stable(out_col)
                          && $stable(out_row) && $stable(out_run_last)
                          && $stable(out_frame_last)))
    else $error("waiting result changed before transfer");

  // The last pixel of a frame also ends the run of its input pixel.
  a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_last) |-> out_run_last)
    else $error("frame end without run end");

endmodule

bind gaussian_pyramid_reduce_5tap gpr5_checker u_gpr5_checker (.*);
